### rtl/core/blt_pkg.sv
// ----------------------------------------------------------------------------
// Blitter package
// Shared types, codes and sizes of the clipped rectangle blitter core.
// ----------------------------------------------------------------------------
package blt_pkg;

   localparam int MAX_DIM_DEFAULT = 64;

   localparam int ADDR_W     = 12;
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 7;
   localparam int POS_W      = 8;
   localparam int CNT_W      = 13;
   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSP_COLOR = 3'd5;

   localparam logic [1:0] MODE_MASK   = 2'd0;
   localparam logic [1:0] MODE_OPAQUE = 2'd1;
   localparam logic [1:0] MODE_KEY    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET   = 7'd64;
   localparam logic [1:0]       MODE_RESET  = MODE_MASK;
   localparam logic [PIX_W-1:0] COLOR_RESET = 8'd0;

   typedef enum logic [1:0] {
      CMD_SRC_WR,
      CMD_DST_WR,
      CMD_DST_RD,
      CMD_BLIT
   } cmd_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type pos;
      coord_type other;
      coord_type len;
      coord_type limit;
   } clip_req_type;

   typedef struct packed {
      coord_type pos;
      coord_type other;
      coord_type len;
   } clip_res_type;

endpackage

### rtl/core/clipped_rect_blitter_core.sv
// ----------------------------------------------------------------------------
// Clipped rectangle blitter core
// 8-bit indexed blitter with a source store (pixel plus mask bit), a
// destination store, clipping and three transparency modes.
// ----------------------------------------------------------------------------
// Load and read words are taken one per cycle while busy is low; each gives
// its result strobe in the cycle after it is taken, read data coming from the
// registered read port of the destination store. A blit raises busy for four
// clip steps of the shared clip unit, three row base multiply-add steps, a
// walk of one pixel per cycle over the clipped rectangle through the source
// store read port and a drain step for the last write; its strobe follows in
// the next cycle. A blit clipped away by the destination or the source ends
// after the clip steps of that surface. Results are never held back, so a
// receiver must take each strobe as it comes. Stores are not cleared.
// ----------------------------------------------------------------------------
module clipped_rect_blitter_core #(
   parameter int MAX_DIM = blt_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_cmd,
   input  logic [blt_pkg::ADDR_W-1:0]       req_address,
   input  logic [blt_pkg::PIX_W-1:0]        req_pixel,
   input  logic                             req_mask_set,
   input  logic                             req_full_source,
   input  logic signed [blt_pkg::POS_W-1:0] req_src_x,
   input  logic signed [blt_pkg::POS_W-1:0] req_src_y,
   input  logic [blt_pkg::DIM_W-1:0]        req_rect_w,
   input  logic [blt_pkg::DIM_W-1:0]        req_rect_h,
   input  logic signed [blt_pkg::POS_W-1:0] req_dst_x,
   input  logic signed [blt_pkg::POS_W-1:0] req_dst_y,
   output logic                             rsp_strobe,
   output logic [blt_pkg::PIX_W-1:0]        rsp_read_data,
   output logic                             rsp_status,
   output logic [blt_pkg::CNT_W-1:0]        rsp_written_count,
   input  logic                             csr_we,
   input  logic [blt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_DIM);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP_DX,
      ST_CLIP_DY,
      ST_CLIP_SX,
      ST_CLIP_SY,
      ST_BASE_S,
      ST_BASE_D,
      ST_BASE_W,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type state_ff;

   logic [blt_pkg::DIM_W-1:0] src_width_ff;
   logic [blt_pkg::DIM_W-1:0] src_height_ff;
   logic [blt_pkg::DIM_W-1:0] dst_width_ff;
   logic [blt_pkg::DIM_W-1:0] dst_height_ff;
   logic [1:0]                blit_mode_ff;
   logic [blt_pkg::PIX_W-1:0] transp_color_ff;

   blt_pkg::coord_type sw_eff, sh_eff, dw_eff, dh_eff;
   blt_pkg::coord_type sx_ff, sy_ff, dx_ff, dy_ff, w_ff, h_ff;

   blt_pkg::clip_req_type clip_req;
   blt_pkg::clip_res_type clip_res;

   logic [AW-1:0] mac_row, mac_stride, mac_col, mac_index;
   logic [AW-1:0] sbase_ff, dbase_ff, di_ff;
   logic [COL_W-1:0] col_ff, row_ff;
   logic col_last, row_last;

   logic accept;
   blt_pkg::cmd_type cmd;
   logic addr_ok;
   logic [AW-1:0] load_addr;

   logic rsp_strobe_ff, status_ff, rd_sel_ff, wr_pend_ff;
   logic [blt_pkg::CNT_W-1:0] count_ff;

   logic                      src_we;
   logic [AW-1:0]             src_raddr;
   logic [blt_pkg::PIX_W:0]   src_q;
   logic                      dst_we;
   logic [AW-1:0]             dst_waddr;
   logic [blt_pkg::PIX_W-1:0] dst_wdata;
   logic [blt_pkg::PIX_W-1:0] dst_q;
   logic                      skip;
   logic                      blit_we;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= blt_pkg::DIM_RESET;
         src_height_ff   <= blt_pkg::DIM_RESET;
         dst_width_ff    <= blt_pkg::DIM_RESET;
         dst_height_ff   <= blt_pkg::DIM_RESET;
         blit_mode_ff    <= blt_pkg::MODE_RESET;
         transp_color_ff <= blt_pkg::COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            blt_pkg::REG_SRC_WIDTH:    src_width_ff    <= csr_wdata[blt_pkg::DIM_W-1:0];
            blt_pkg::REG_SRC_HEIGHT:   src_height_ff   <= csr_wdata[blt_pkg::DIM_W-1:0];
            blt_pkg::REG_DST_WIDTH:    dst_width_ff    <= csr_wdata[blt_pkg::DIM_W-1:0];
            blt_pkg::REG_DST_HEIGHT:   dst_height_ff   <= csr_wdata[blt_pkg::DIM_W-1:0];
            blt_pkg::REG_BLIT_MODE:    blit_mode_ff    <= csr_wdata[1:0];
            blt_pkg::REG_TRANSP_COLOR: transp_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate sizes to the store dimension
   always_comb begin
      sw_eff = (32'(src_width_ff) > MAX_DIM) ? blt_pkg::coord_type'(MAX_DIM)
                                             : blt_pkg::coord_type'(src_width_ff);
      sh_eff = (32'(src_height_ff) > MAX_DIM) ? blt_pkg::coord_type'(MAX_DIM)
                                              : blt_pkg::coord_type'(src_height_ff);
      dw_eff = (32'(dst_width_ff) > MAX_DIM) ? blt_pkg::coord_type'(MAX_DIM)
                                             : blt_pkg::coord_type'(dst_width_ff);
      dh_eff = (32'(dst_height_ff) > MAX_DIM) ? blt_pkg::coord_type'(MAX_DIM)
                                              : blt_pkg::coord_type'(dst_height_ff);
   end

   // ---------------------------------------------------------------- command
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy && !reset;
   assign cmd       = blt_pkg::cmd_type'(req_cmd);
   assign addr_ok   = (32'(req_address) < STORE_DEPTH);
   assign load_addr = AW'(req_address);

   // ---------------------------------------------------------------- clip unit
   always_comb begin
      unique case (state_ff)
         ST_CLIP_DY: clip_req = '{pos: dy_ff, other: sy_ff, len: h_ff, limit: dh_eff};
         ST_CLIP_SX: clip_req = '{pos: sx_ff, other: dx_ff, len: w_ff, limit: sw_eff};
         ST_CLIP_SY: clip_req = '{pos: sy_ff, other: dy_ff, len: h_ff, limit: sh_eff};
         default:    clip_req = '{pos: dx_ff, other: sx_ff, len: w_ff, limit: dw_eff};
      endcase
   end

   blt_clip u_clip (
      .clip_req (clip_req),
      .clip_res (clip_res)
   );

   // ---------------------------------------------------------------- row base
   always_comb begin
      if (state_ff == ST_BASE_D) begin
         mac_row    = AW'(dy_ff);
         mac_stride = AW'(dw_eff);
         mac_col    = AW'(dx_ff);
      end else begin
         mac_row    = AW'(sy_ff);
         mac_stride = AW'(sw_eff);
         mac_col    = AW'(sx_ff);
      end
   end

   blt_mac #(
      .AW (AW)
   ) u_mac (
      .clock  (clock),
      .row    (mac_row),
      .stride (mac_stride),
      .col    (mac_col),
      .index  (mac_index)
   );

   assign col_last = (blt_pkg::coord_type'(col_ff) == (w_ff - blt_pkg::coord_type'(1)));
   assign row_last = (blt_pkg::coord_type'(row_ff) == (h_ff - blt_pkg::coord_type'(1)));

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         wr_pend_ff    <= (state_ff == ST_WALK);
         count_ff      <= count_ff + blt_pkg::CNT_W'(blit_we);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff  <= '0;
                  status_ff <= 1'b0;
                  rd_sel_ff <= (cmd == blt_pkg::CMD_DST_RD) && addr_ok;
                  if (cmd == blt_pkg::CMD_BLIT) begin
                     state_ff <= ST_CLIP_DX;
                     dx_ff    <= blt_pkg::coord_type'(req_dst_x);
                     dy_ff    <= blt_pkg::coord_type'(req_dst_y);
                     if (req_full_source) begin
                        sx_ff <= '0;
                        sy_ff <= '0;
                        w_ff  <= sw_eff;
                        h_ff  <= sh_eff;
                     end else begin
                        sx_ff <= blt_pkg::coord_type'(req_src_x);
                        sy_ff <= blt_pkg::coord_type'(req_src_y);
                        w_ff  <= blt_pkg::coord_type'(req_rect_w);
                        h_ff  <= blt_pkg::coord_type'(req_rect_h);
                     end
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                  end
               end
            end
            ST_CLIP_DX: begin
               dx_ff    <= clip_res.pos;
               sx_ff    <= clip_res.other;
               w_ff     <= clip_res.len;
               state_ff <= ST_CLIP_DY;
            end
            ST_CLIP_DY: begin
               dy_ff <= clip_res.pos;
               sy_ff <= clip_res.other;
               h_ff  <= clip_res.len;
               if ((w_ff <= 0) || (clip_res.len <= 0)) begin
                  status_ff     <= 1'b1;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_CLIP_SX;
               end
            end
            ST_CLIP_SX: begin
               sx_ff    <= clip_res.pos;
               dx_ff    <= clip_res.other;
               w_ff     <= clip_res.len;
               state_ff <= ST_CLIP_SY;
            end
            ST_CLIP_SY: begin
               sy_ff <= clip_res.pos;
               dy_ff <= clip_res.other;
               h_ff  <= clip_res.len;
               if ((w_ff <= 0) || (clip_res.len <= 0)) begin
                  status_ff     <= 1'b1;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_BASE_S;
               end
            end
            ST_BASE_S: begin
               state_ff <= ST_BASE_D;
            end
            ST_BASE_D: begin
               sbase_ff <= mac_index;
               state_ff <= ST_BASE_W;
            end
            ST_BASE_W: begin
               dbase_ff <= mac_index;
               col_ff   <= '0;
               row_ff   <= '0;
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               di_ff <= dbase_ff + AW'(col_ff);
               if (col_last) begin
                  col_ff <= '0;
                  if (row_last) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     row_ff   <= row_ff + COL_W'(1);
                     sbase_ff <= sbase_ff + AW'(sw_eff);
                     dbase_ff <= dbase_ff + AW'(dw_eff);
                  end
               end else begin
                  col_ff <= col_ff + COL_W'(1);
               end
            end
            ST_DRAIN: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- stores
   assign src_we    = accept && (cmd == blt_pkg::CMD_SRC_WR) && addr_ok;
   assign src_raddr = sbase_ff + AW'(col_ff);

   blt_ram #(
      .WIDTH (blt_pkg::PIX_W + 1),
      .DEPTH (STORE_DEPTH)
   ) u_src_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (load_addr),
      .wdata ({req_mask_set, req_pixel}),
      .raddr (src_raddr),
      .rdata (src_q)
   );

   always_comb begin
      case (blit_mode_ff)
         blt_pkg::MODE_KEY:    skip = (src_q[blt_pkg::PIX_W-1:0] == transp_color_ff);
         blt_pkg::MODE_OPAQUE: skip = 1'b0;
         default:              skip = src_q[blt_pkg::PIX_W];
      endcase
   end

   assign blit_we   = wr_pend_ff && !skip;
   assign dst_we    = blit_we || (accept && (cmd == blt_pkg::CMD_DST_WR) && addr_ok);
   assign dst_waddr = wr_pend_ff ? di_ff : load_addr;
   assign dst_wdata = wr_pend_ff ? src_q[blt_pkg::PIX_W-1:0] : req_pixel;

   blt_ram #(
      .WIDTH (blt_pkg::PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_dst_ram (
      .clock (clock),
      .we    (dst_we),
      .waddr (dst_waddr),
      .wdata (dst_wdata),
      .raddr (load_addr),
      .rdata (dst_q)
   );

   // ---------------------------------------------------------------- result
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_data     = rd_sel_ff ? dst_q : '0;
   assign rsp_status        = status_ff;
   assign rsp_written_count = count_ff;

endmodule

### rtl/core/blt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/blt_clip.sv
// ----------------------------------------------------------------------------
// Blitter clip unit
// Clips one axis of the rectangle against one surface edge pair; the
// sequencer runs it once per axis for the destination and then the source.
// ----------------------------------------------------------------------------
module blt_clip (
   input  blt_pkg::clip_req_type clip_req,
   output blt_pkg::clip_res_type clip_res
);

   blt_pkg::coord_type pos;
   blt_pkg::coord_type other;
   blt_pkg::coord_type len;
   blt_pkg::coord_type limit;
   blt_pkg::coord_type reach;
   blt_pkg::coord_type len_cut;

   always_comb begin
      pos     = clip_req.pos;
      other   = clip_req.other;
      len     = clip_req.len;
      limit   = clip_req.limit;
      reach   = pos + len;
      len_cut = (reach > limit) ? (limit - pos) : len;
      if (pos < 0) begin
         clip_res.len   = len_cut + pos;
         clip_res.other = other - pos;
         clip_res.pos   = '0;
      end else begin
         clip_res.len   = len_cut;
         clip_res.other = other;
         clip_res.pos   = pos;
      end
   end

endmodule

### rtl/core/blt_mac.sv
// ----------------------------------------------------------------------------
// Blitter row base unit
// Registered multiply-add that turns a row and column into a linear index.
// ----------------------------------------------------------------------------
module blt_mac #(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic [AW-1:0] row,
   input  logic [AW-1:0] stride,
   input  logic [AW-1:0] col,
   output logic [AW-1:0] index
);

   logic [2*AW-1:0] prod;
   logic [AW-1:0]   index_in;
   logic [AW-1:0]   index_ff;

   assign prod     = row * stride;
   assign index_in = prod[AW-1:0] + col;

   always_ff @(posedge clock) begin
      index_ff <= index_in;
   end

   assign index = index_ff;

endmodule

### rtl/core/blt_checker.sv
// ----------------------------------------------------------------------------
// Blitter port checker
// Port-level properties of the blitter core, bound to the core module.
// ----------------------------------------------------------------------------
module blt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [1:0]                      req_cmd,
   input logic                            rsp_strobe,
   input logic [blt_pkg::PIX_W-1:0]       rsp_read_data,
   input logic                            rsp_status,
   input logic [blt_pkg::CNT_W-1:0]       rsp_written_count
);

   logic accept;
   assign accept = start && !busy;

   // results only come out once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word while busy");

   // load and read words answer in the next cycle
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd != blt_pkg::CMD_BLIT)) |=> (rsp_strobe && !busy))
      else $error("load or read word not answered next cycle");

   // a blit occupies the block
   a_blit_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == blt_pkg::CMD_BLIT)) |=> (busy && !rsp_strobe))
      else $error("blit word did not raise busy");

   // a failed blit writes nothing and reads nothing
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> ((rsp_written_count == '0) && (rsp_read_data == '0)))
      else $error("failed blit with nonzero payload");

endmodule

bind clipped_rect_blitter_core blt_checker u_blt_checker (.*);
